// ===== hw/rtl/ec_point_add_mod_p_top_macros.svh =====
// Assertion macros for the point adder.
`ifndef EC_POINT_ADD_MOD_P_TOP_MACROS_SVH
`define EC_POINT_ADD_MOD_P_TOP_MACROS_SVH

// same-cycle implication
`define ECPA_AST_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ecpa assertion failed");

// next-cycle implication
`define ECPA_AST_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ecpa assertion failed");

`endif

// ===== hw/rtl/ecpa_pkg.sv =====
// ----------------------------------------------------------------------------
// ecpa_pkg
// Shared types, command codes and modular helpers for the point adder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ecpa_pkg;

    localparam int W    = 32;
    localparam int CW   = $clog2(W);

    typedef logic [W-1:0] t_word;

    typedef enum logic [4:0] {
        OP_NOP, OP_LOAD, OP_DIV, OP_RED_WB, OP_MUL,
        OP_TAN1, OP_TAN2, OP_TAN3, OP_CHORD, OP_EINIT,
        OP_EQ, OP_ET, OP_LAM, OP_RX1, OP_RX2, OP_TMP, OP_RY, OP_INF
    } t_op;

    typedef enum logic [2:0] {
        DS_PX, DS_PY, DS_QX, DS_QY, DS_A, DS_EUC
    } t_dsel;

    typedef enum logic [2:0] {
        MS_PXPX, MS_NUMT0, MS_QT1, MS_LAMLAM, MS_LAMTMP
    } t_msel;

    typedef struct packed {
        t_op   op;
        t_dsel dsel;
        t_msel msel;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic mul_done;
        logic inf;
        logic dbl;
        logic r1_zero;
    } t_stat;

    // a, b < m
    function automatic t_word add_m(input t_word a, input t_word b, input t_word m);
        logic [W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[W-1:0];
    endfunction

    // a, b < m; wraparound gives the right residue
    function automatic t_word sub_m(input t_word a, input t_word b, input t_word m);
        t_word d;
        if (a >= b) begin
            d = a - b;
        end else begin
            d = a + (m - b);
        end
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ecpa_dp.sv =====
// ----------------------------------------------------------------------------
// ecpa_dp
// Datapath: operand registers, bit-serial divider, bit-serial modular multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ecpa_dp (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire ecpa_pkg::t_cmd i_cmd,
    output ecpa_pkg::t_stat     o_stat,
    input  wire logic           i_cfg_we,
    input  wire logic           i_cfg_idx,
    input  wire ecpa_pkg::t_word i_cfg_data,
    input  wire ecpa_pkg::t_word i_p_x,
    input  wire ecpa_pkg::t_word i_p_y,
    input  wire ecpa_pkg::t_word i_q_x,
    input  wire ecpa_pkg::t_word i_q_y,
    output logic                o_done,
    output ecpa_pkg::t_word     o_r_x,
    output ecpa_pkg::t_word     o_r_y,
    output logic                o_at_infinity
);

    ecpa_pkg::t_word r_cfg_a, r_cfg_m;
    ecpa_pkg::t_word r_m, r_px, r_py, r_qx, r_qy, r_a;
    ecpa_pkg::t_word r_num, r_den, r_lam, r_rx, r_tmp;
    ecpa_pkg::t_word r_r0, r_r1, r_t0, r_t1, r_qm;
    // divider
    ecpa_pkg::t_word   r_dn, r_dd, r_quot, r_rem;
    logic [ecpa_pkg::CW-1:0] r_dcnt;
    logic              r_dbusy;
    // multiplier
    ecpa_pkg::t_word   r_ma, r_mb, r_acc;
    logic [ecpa_pkg::CW-1:0] r_mcnt;
    logic              r_mbusy;
    // result
    ecpa_pkg::t_word   r_ox, r_oy;
    logic              r_oinf, r_ostb;

    logic [ecpa_pkg::W:0] rem_sh;
    logic                 q_bit;
    ecpa_pkg::t_word      n_rem, mul_dbl, n_acc, div_src, n_ry;

    always_comb begin
        rem_sh = {r_rem, r_dn[ecpa_pkg::W-1]};
        q_bit  = (rem_sh >= {1'b0, r_dd});
        n_rem  = q_bit ? ecpa_pkg::W'(rem_sh - {1'b0, r_dd}) : rem_sh[ecpa_pkg::W-1:0];
        mul_dbl = ecpa_pkg::add_m(r_acc, r_acc, r_m);
        n_acc  = r_mb[ecpa_pkg::W-1] ? ecpa_pkg::add_m(mul_dbl, r_ma, r_m) : mul_dbl;
        n_ry   = ecpa_pkg::sub_m(r_acc, r_py, r_m);
        case (i_cmd.dsel)
            ecpa_pkg::DS_PX:  div_src = r_px;
            ecpa_pkg::DS_PY:  div_src = r_py;
            ecpa_pkg::DS_QX:  div_src = r_qx;
            ecpa_pkg::DS_QY:  div_src = r_qy;
            ecpa_pkg::DS_A:   div_src = r_a;
            default:          div_src = r_r0;
        endcase
    end

    assign o_stat.div_done = !r_dbusy;
    assign o_stat.mul_done = !r_mbusy;
    assign o_stat.inf      = (r_px == r_qx) && (ecpa_pkg::add_m(r_py, r_qy, r_m) == '0);
    assign o_stat.dbl      = (r_px == r_qx) && (r_py == r_qy);
    assign o_stat.r1_zero  = (r_r1 == '0);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_a <= '0;
            r_cfg_m <= ecpa_pkg::W'(23);
            r_dbusy <= 1'b0;
            r_mbusy <= 1'b0;
            r_dcnt  <= '0;
            r_mcnt  <= '0;
            r_ostb  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx) r_cfg_m <= i_cfg_data;
                else           r_cfg_a <= i_cfg_data;
            end
            r_ostb <= (i_cmd.op == ecpa_pkg::OP_RY) || (i_cmd.op == ecpa_pkg::OP_INF);
            if (i_cmd.op == ecpa_pkg::OP_DIV) begin
                r_dbusy <= 1'b1;
                r_dcnt  <= '0;
            end else if (r_dbusy) begin
                r_dcnt <= r_dcnt + 1'b1;
                if (r_dcnt == ecpa_pkg::CW'(ecpa_pkg::W - 1)) r_dbusy <= 1'b0;
            end
            if (i_cmd.op == ecpa_pkg::OP_MUL) begin
                r_mbusy <= 1'b1;
                r_mcnt  <= '0;
            end else if (r_mbusy) begin
                r_mcnt <= r_mcnt + 1'b1;
                if (r_mcnt == ecpa_pkg::CW'(ecpa_pkg::W - 1)) r_mbusy <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (r_dbusy) begin
            r_rem  <= n_rem;
            r_dn   <= {r_dn[ecpa_pkg::W-2:0], 1'b0};
            r_quot <= {r_quot[ecpa_pkg::W-2:0], q_bit};
        end
        if (r_mbusy) begin
            r_acc <= n_acc;
            r_mb  <= {r_mb[ecpa_pkg::W-2:0], 1'b0};
        end
        case (i_cmd.op)
            ecpa_pkg::OP_LOAD: begin
                r_px <= i_p_x;
                r_py <= i_p_y;
                r_qx <= i_q_x;
                r_qy <= i_q_y;
                r_a  <= r_cfg_a;
                r_m  <= (r_cfg_m == '0) ? ecpa_pkg::W'(1) : r_cfg_m;
            end
            ecpa_pkg::OP_DIV: begin
                r_dn   <= div_src;
                r_dd   <= (i_cmd.dsel == ecpa_pkg::DS_EUC) ? r_r1 : r_m;
                r_rem  <= '0;
                r_quot <= '0;
            end
            ecpa_pkg::OP_RED_WB: begin
                case (i_cmd.dsel)
                    ecpa_pkg::DS_PX: r_px <= r_rem;
                    ecpa_pkg::DS_PY: r_py <= r_rem;
                    ecpa_pkg::DS_QX: r_qx <= r_rem;
                    ecpa_pkg::DS_QY: r_qy <= r_rem;
                    default:         r_a  <= r_rem;
                endcase
            end
            ecpa_pkg::OP_MUL: begin
                r_acc <= '0;
                case (i_cmd.msel)
                    ecpa_pkg::MS_PXPX:   begin r_ma <= r_px;  r_mb <= r_px;  end
                    ecpa_pkg::MS_NUMT0:  begin r_ma <= r_num; r_mb <= r_t0;  end
                    ecpa_pkg::MS_QT1:    begin r_ma <= r_qm;  r_mb <= r_t1;  end
                    ecpa_pkg::MS_LAMLAM: begin r_ma <= r_lam; r_mb <= r_lam; end
                    default:             begin r_ma <= r_lam; r_mb <= r_tmp; end
                endcase
            end
            ecpa_pkg::OP_TAN1: begin
                r_num <= ecpa_pkg::add_m(r_acc, r_acc, r_m);
                r_den <= ecpa_pkg::add_m(r_py, r_py, r_m);
            end
            ecpa_pkg::OP_TAN2: r_num <= ecpa_pkg::add_m(r_num, r_acc, r_m);
            ecpa_pkg::OP_TAN3: r_num <= ecpa_pkg::add_m(r_num, r_a, r_m);
            ecpa_pkg::OP_CHORD: begin
                r_num <= ecpa_pkg::sub_m(r_qy, r_py, r_m);
                r_den <= ecpa_pkg::sub_m(r_qx, r_px, r_m);
            end
            ecpa_pkg::OP_EINIT: begin
                r_r0 <= r_m;
                r_r1 <= r_den;
                r_t0 <= '0;
                r_t1 <= (r_m > ecpa_pkg::W'(1)) ? ecpa_pkg::W'(1) : '0;
            end
            ecpa_pkg::OP_EQ: begin
                // quotient reaches m only on the first step with v = 1
                r_qm <= (r_quot >= r_m) ? r_quot - r_m : r_quot;
                r_r0 <= r_r1;
                r_r1 <= r_rem;
            end
            ecpa_pkg::OP_ET: begin
                r_t1 <= ecpa_pkg::sub_m(r_t0, r_acc, r_m);
                r_t0 <= r_t1;
            end
            ecpa_pkg::OP_LAM: r_lam <= r_acc;
            ecpa_pkg::OP_RX1: r_rx  <= ecpa_pkg::sub_m(r_acc, r_px, r_m);
            ecpa_pkg::OP_RX2: r_rx  <= ecpa_pkg::sub_m(r_rx, r_qx, r_m);
            ecpa_pkg::OP_TMP: r_tmp <= ecpa_pkg::sub_m(r_px, r_rx, r_m);
            ecpa_pkg::OP_RY: begin
                r_ox   <= r_rx;
                r_oy   <= n_ry;
                r_oinf <= 1'b0;
            end
            ecpa_pkg::OP_INF: begin
                r_ox   <= '0;
                r_oy   <= '0;
                r_oinf <= 1'b1;
            end
            default: ;
        endcase
    end

    assign o_done        = r_ostb;
    assign o_r_x         = r_ox;
    assign o_r_y         = r_oy;
    assign o_at_infinity = r_oinf;

endmodule

`default_nettype wire

// ===== hw/rtl/ecpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// ecpa_ctrl
// Sequencer: steps reductions, slope, Euclidean inverse and result formation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ecpa_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    output logic                 o_busy,
    input  wire ecpa_pkg::t_stat i_stat,
    output ecpa_pkg::t_cmd       o_cmd
);

    typedef enum logic [20:0] {
        S_IDLE  = 21'd1 << 0,  S_RED   = 21'd1 << 1,  S_REDWB = 21'd1 << 2,
        S_CLS   = 21'd1 << 3,  S_TAN1  = 21'd1 << 4,  S_TAN2  = 21'd1 << 5,
        S_TAN3  = 21'd1 << 6,  S_EINIT = 21'd1 << 7,  S_ECHK  = 21'd1 << 8,
        S_EQ    = 21'd1 << 9,  S_EMUL  = 21'd1 << 10, S_ET    = 21'd1 << 11,
        S_LAM   = 21'd1 << 12, S_SQ    = 21'd1 << 13, S_RX1   = 21'd1 << 14,
        S_RX2   = 21'd1 << 15, S_TMP   = 21'd1 << 16, S_YMUL  = 21'd1 << 17,
        S_RY    = 21'd1 << 18, S_WDIV  = 21'd1 << 19, S_WMUL  = 21'd1 << 20
    } t_state;

    t_state r_state, n_state, r_ret, n_ret;
    ecpa_pkg::t_dsel r_k, n_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_k     <= ecpa_pkg::DS_PX;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_k     <= n_k;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_k         = r_k;
        o_cmd.op    = ecpa_pkg::OP_NOP;
        o_cmd.dsel  = r_k;
        o_cmd.msel  = ecpa_pkg::MS_PXPX;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.op = ecpa_pkg::OP_LOAD;
                    n_k      = ecpa_pkg::DS_PX;
                    n_state  = S_RED;
                end
            end
            S_RED: begin
                o_cmd.op = ecpa_pkg::OP_DIV;
                n_ret    = S_REDWB;
                n_state  = S_WDIV;
            end
            S_REDWB: begin
                o_cmd.op = ecpa_pkg::OP_RED_WB;
                n_state  = S_RED;
                case (r_k)
                    ecpa_pkg::DS_PX: n_k = ecpa_pkg::DS_PY;
                    ecpa_pkg::DS_PY: n_k = ecpa_pkg::DS_QX;
                    ecpa_pkg::DS_QX: n_k = ecpa_pkg::DS_QY;
                    ecpa_pkg::DS_QY: n_k = ecpa_pkg::DS_A;
                    default:         n_state = S_CLS;
                endcase
            end
            S_CLS: begin
                if (i_stat.inf) begin
                    o_cmd.op = ecpa_pkg::OP_INF;
                    n_state  = S_IDLE;
                end else if (i_stat.dbl) begin
                    o_cmd.op   = ecpa_pkg::OP_MUL;
                    o_cmd.msel = ecpa_pkg::MS_PXPX;
                    n_ret      = S_TAN1;
                    n_state    = S_WMUL;
                end else begin
                    o_cmd.op = ecpa_pkg::OP_CHORD;
                    n_state  = S_EINIT;
                end
            end
            S_TAN1: begin o_cmd.op = ecpa_pkg::OP_TAN1; n_state = S_TAN2; end
            S_TAN2: begin o_cmd.op = ecpa_pkg::OP_TAN2; n_state = S_TAN3; end
            S_TAN3: begin o_cmd.op = ecpa_pkg::OP_TAN3; n_state = S_EINIT; end
            S_EINIT: begin o_cmd.op = ecpa_pkg::OP_EINIT; n_state = S_ECHK; end
            S_ECHK: begin
                if (i_stat.r1_zero) begin
                    o_cmd.op   = ecpa_pkg::OP_MUL;
                    o_cmd.msel = ecpa_pkg::MS_NUMT0;
                    n_ret      = S_LAM;
                    n_state    = S_WMUL;
                end else begin
                    o_cmd.op   = ecpa_pkg::OP_DIV;
                    o_cmd.dsel = ecpa_pkg::DS_EUC;
                    n_ret      = S_EQ;
                    n_state    = S_WDIV;
                end
            end
            S_EQ: begin o_cmd.op = ecpa_pkg::OP_EQ; n_state = S_EMUL; end
            S_EMUL: begin
                o_cmd.op   = ecpa_pkg::OP_MUL;
                o_cmd.msel = ecpa_pkg::MS_QT1;
                n_ret      = S_ET;
                n_state    = S_WMUL;
            end
            S_ET: begin o_cmd.op = ecpa_pkg::OP_ET; n_state = S_ECHK; end
            S_LAM: begin o_cmd.op = ecpa_pkg::OP_LAM; n_state = S_SQ; end
            S_SQ: begin
                o_cmd.op   = ecpa_pkg::OP_MUL;
                o_cmd.msel = ecpa_pkg::MS_LAMLAM;
                n_ret      = S_RX1;
                n_state    = S_WMUL;
            end
            S_RX1: begin o_cmd.op = ecpa_pkg::OP_RX1; n_state = S_RX2; end
            S_RX2: begin o_cmd.op = ecpa_pkg::OP_RX2; n_state = S_TMP; end
            S_TMP: begin o_cmd.op = ecpa_pkg::OP_TMP; n_state = S_YMUL; end
            S_YMUL: begin
                o_cmd.op   = ecpa_pkg::OP_MUL;
                o_cmd.msel = ecpa_pkg::MS_LAMTMP;
                n_ret      = S_RY;
                n_state    = S_WMUL;
            end
            S_RY: begin o_cmd.op = ecpa_pkg::OP_RY; n_state = S_IDLE; end
            S_WDIV: if (i_stat.div_done) n_state = r_ret;
            S_WMUL: if (i_stat.mul_done) n_state = r_ret;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

// ===== hw/rtl/ec_point_add_mod_p_top.sv =====
// ----------------------------------------------------------------------------
// ec_point_add_mod_p_top
// Affine point addition R = P + Q on a short Weierstrass curve mod p.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; the result shows on
// o_r_x/o_r_y/o_at_infinity, held until the next result, with o_done, which is
// high for a single cycle; the result cannot be stalled. Every divide and
// modular multiply runs one bit per cycle. Work runs in order: operand
// reduction and the inverse-point check, then the extended-Euclid steps (up to
// ~46 steps), then lambda, x and y. Inverse points finish after the reduction
// phase. A new request can be taken in the cycle that o_done is shown.
`timescale 1ns / 1ps
`default_nettype none
`include "ec_point_add_mod_p_top_macros.svh"

module ec_point_add_mod_p_top (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire logic            i_cfg_we,
    input  wire logic            i_cfg_idx,
    input  wire ecpa_pkg::t_word i_cfg_data,
    input  wire ecpa_pkg::t_word i_p_x,
    input  wire ecpa_pkg::t_word i_p_y,
    input  wire ecpa_pkg::t_word i_q_x,
    input  wire ecpa_pkg::t_word i_q_y,
    output logic                 o_done,
    output ecpa_pkg::t_word      o_r_x,
    output ecpa_pkg::t_word      o_r_y,
    output logic                 o_at_infinity
);

    ecpa_pkg::t_cmd  cmd;
    ecpa_pkg::t_stat stat;

    ecpa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    ecpa_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_p_x         (i_p_x),
        .i_p_y         (i_p_y),
        .i_q_x         (i_q_x),
        .i_q_y         (i_q_y),
        .o_done        (o_done),
        .o_r_x         (o_r_x),
        .o_r_y         (o_r_y),
        .o_at_infinity (o_at_infinity)
    );

    `ECPA_AST_NXT(a_accept_busy, start && !busy, busy)
    `ECPA_AST_NOW(a_inf_zero, o_done && o_at_infinity, (o_r_x == '0) && (o_r_y == '0))
    `ECPA_AST_NXT(a_done_single, o_done, !o_done)
    `ECPA_AST_NOW(a_done_after_busy, o_done, !$past(busy) == 1'b0)

endmodule

`default_nettype wire

// ===== sim/ecpa_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// ecpa_tb_pkg
// Register indexes shared by the point adder testbench and its checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ecpa_tb_pkg;

    localparam logic REG_CURVE_A       = 1'b0;
    localparam logic REG_PRIME_MODULUS = 1'b1;

endpackage

// ===== sim/ecpa_checker.sv =====
// ----------------------------------------------------------------------------
// ecpa_checker
// Watches the point adder ports, predicts each sum and compares the results.
// ----------------------------------------------------------------------------
// Keeps its own copy of curve_a and the modulus from the config port, works out
// R = P + Q for every accepted request and checks each o_done against the
// oldest pending sum.
`timescale 1ns / 1ps

module ecpa_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  logic            busy,
    input  logic            i_cfg_we,
    input  logic            i_cfg_idx,
    input  ecpa_pkg::t_word i_cfg_data,
    input  ecpa_pkg::t_word i_p_x,
    input  ecpa_pkg::t_word i_p_y,
    input  ecpa_pkg::t_word i_q_x,
    input  ecpa_pkg::t_word i_q_y,
    input  logic            o_done,
    input  ecpa_pkg::t_word o_r_x,
    input  ecpa_pkg::t_word o_r_y,
    input  logic            o_at_infinity,
    output int              o_fail_cnt,
    output int              o_pending,
    output int              o_sum_cnt,
    output int              o_inf_cnt
);
    import ecpa_pkg::*;
    import ecpa_tb_pkg::*;

    typedef logic [63:0] t_wide;

    typedef struct {
        t_word rx;
        t_word ry;
        logic  inf;
    } t_sum;

    t_sum  sums_q[$];
    t_word coef_a;
    t_word modulus;

    function automatic t_wide fadd(t_wide a, t_wide b, t_wide m);
        t_wide s;
        s = a + b;
        return (s >= m) ? s - m : s;
    endfunction

    function automatic t_wide fsub(t_wide a, t_wide b, t_wide m);
        return (a >= b) ? a - b : a + (m - b);
    endfunction

    function automatic t_wide fmul(t_wide a, t_wide b, t_wide m);
        logic [127:0] prod;
        prod = a * b;
        return t_wide'(prod % m);
    endfunction

    // Bezout coefficient of v mod m; 0 maps to 0
    function automatic t_wide finv(t_wide v, t_wide m);
        t_wide r0, r1, t0, t1, qt, rn, tn;
        r0 = m;
        r1 = v;
        t0 = 0;
        t1 = (m > 1) ? 1 : 0;
        while (r1 != 0) begin
            qt = r0 / r1;
            rn = r0 - qt * r1;
            tn = fsub(t0, fmul(qt % m, t1, m), m);
            r0 = r1;
            r1 = rn;
            t0 = t1;
            t1 = tn;
        end
        return t0;
    endfunction

    function automatic t_sum point_sum(t_word ipx, t_word ipy, t_word iqx, t_word iqy,
                                       t_word ia, t_word im);
        t_wide m, px, py, qx, qy, a, num, den, lam, x2, rx, ry;
        t_sum  s;
        m = (im == 0) ? 1 : im;
        px = ipx % m;
        py = ipy % m;
        qx = iqx % m;
        qy = iqy % m;
        a  = ia % m;
        if (px == qx && fadd(py, qy, m) == 0) begin
            s.rx = '0;
            s.ry = '0;
            s.inf = 1'b1;
            return s;
        end
        if (px == qx && py == qy) begin
            x2  = fmul(px, px, m);
            num = fadd(fadd(fadd(x2, x2, m), x2, m), a, m);
            den = fadd(py, py, m);
        end else begin
            num = fsub(qy, py, m);
            den = fsub(qx, px, m);
        end
        lam = fmul(num, finv(den, m), m);
        rx = fsub(fsub(fmul(lam, lam, m), px, m), qx, m);
        ry = fsub(fmul(lam, fsub(px, rx, m), m), py, m);
        s.rx = t_word'(rx);
        s.ry = t_word'(ry);
        s.inf = 1'b0;
        return s;
    endfunction

    assign o_pending = sums_q.size();

    always @(posedge i_clk) begin
        t_sum want;
        if (!i_rst_n) begin
            coef_a  <= '0;
            modulus <= 32'd23;
            o_fail_cnt <= 0;
            o_sum_cnt  <= 0;
            o_inf_cnt  <= 0;
            sums_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_CURVE_A) begin
                    coef_a <= i_cfg_data;
                end else begin
                    modulus <= i_cfg_data;
                end
            end
            if (start && !busy) begin
                sums_q.push_back(point_sum(i_p_x, i_p_y, i_q_x, i_q_y, coef_a, modulus));
            end
            if (o_done) begin
                o_sum_cnt <= o_sum_cnt + 1;
                if (o_at_infinity) o_inf_cnt <= o_inf_cnt + 1;
                if (sums_q.size() == 0) begin
                    if (o_fail_cnt < 10) $display("unexpected result at %0t", $time);
                    o_fail_cnt <= o_fail_cnt + 1;
                end else begin
                    want = sums_q.pop_front();
                    if (want.rx !== o_r_x || want.ry !== o_r_y
                            || want.inf !== o_at_infinity) begin
                        if (o_fail_cnt < 10) begin
                            $display("mismatch at %0t: exp x=%h y=%h inf=%b got x=%h y=%h inf=%b",
                                     $time, want.rx, want.ry, want.inf,
                                     o_r_x, o_r_y, o_at_infinity);
                        end
                        o_fail_cnt <= o_fail_cnt + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the elliptic curve point adder.
// ----------------------------------------------------------------------------
// Directed corner points, then random point pairs (doublings, inverses, equal
// x, unreduced operands) under several curve/modulus settings, prime and not.
`timescale 1ns / 1ps

module tb;
    import ecpa_pkg::*;
    import ecpa_tb_pkg::*;

    localparam longint CYCLE_LIMIT = 8000000;
    localparam t_word  BIG_PRIME   = 32'hFFFF_FFFB;

    logic  i_clk;
    logic  i_rst_n;
    logic  start;
    logic  busy;
    logic  i_cfg_we;
    logic  i_cfg_idx;
    t_word i_cfg_data;
    t_word i_p_x, i_p_y, i_q_x, i_q_y;
    logic  o_done;
    t_word o_r_x, o_r_y;
    logic  o_at_infinity;
    int    fail_cnt, pending, sum_cnt, inf_cnt;
    longint cycles;
    t_word cur_mod;
    int    burst;

    ec_point_add_mod_p_top dut (.*);

    ecpa_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_p_x(i_p_x), .i_p_y(i_p_y), .i_q_x(i_q_x), .i_q_y(i_q_y),
        .o_done(o_done), .o_r_x(o_r_x), .o_r_y(o_r_y), .o_at_infinity(o_at_infinity),
        .o_fail_cnt(fail_cnt), .o_pending(pending), .o_sum_cnt(sum_cnt),
        .o_inf_cnt(inf_cnt)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic write_reg(logic idx, t_word val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == REG_PRIME_MODULUS) cur_mod = val;
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_req(t_word px, t_word py, t_word qx, t_word qy);
        int gap;
        if (burst == 0) begin
            start = 1'b0;
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
            repeat (gap) @(negedge i_clk);
            burst = $urandom_range(1, 8);
        end
        burst--;
        start = 1'b1;
        i_p_x = px;
        i_p_y = py;
        i_q_x = qx;
        i_q_y = qy;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    function automatic t_word residue(t_word m);
        return (m < 2) ? $urandom : t_word'($urandom % m);
    endfunction

    task automatic random_req();
        t_word px, py, qx, qy;
        int kind;
        px = residue(cur_mod);
        py = residue(cur_mod);
        qx = residue(cur_mod);
        qy = residue(cur_mod);
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1: begin
                px = $urandom; py = $urandom; qx = $urandom; qy = $urandom;
            end
            2: begin
                qx = px; qy = py;
            end
            3: begin
                qx = px;
                qy = (py == 0 || cur_mod < 2) ? py : cur_mod - py;
            end
            4: qx = px;
            default: ;
        endcase
        send_req(px, py, qx, qy);
    endtask

    task automatic run_phase(t_word a, t_word m, int n);
        write_reg(REG_CURVE_A, a);
        write_reg(REG_PRIME_MODULUS, m);
        repeat (n) random_req();
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_CURVE_A;
        i_cfg_data = '0;
        i_p_x = '0; i_p_y = '0; i_q_x = '0; i_q_y = '0;
        cur_mod = 32'd23;
        burst = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: a = 0, p = 23
        send_req(0, 0, 0, 0);
        send_req(3, 10, 9, 7);
        send_req(3, 10, 3, 10);
        send_req(3, 10, 3, 13);
        send_req(3, 10, 3, 5);
        send_req(0, 0, 5, 0);
        send_req(26, 33, 32, 30);
        send_req('1, '1, '1, '1);
        send_req('1, 0, 0, '1);
        drain();
        write_reg(REG_CURVE_A, '1);
        write_reg(REG_PRIME_MODULUS, BIG_PRIME);
        send_req(BIG_PRIME - 1, BIG_PRIME - 1, BIG_PRIME - 1, BIG_PRIME - 1);
        send_req(BIG_PRIME - 1, 1, BIG_PRIME - 1, BIG_PRIME - 1);
        send_req(1, 2, BIG_PRIME - 1, 0);
        send_req('1, '1, 0, 0);
        drain();
        write_reg(REG_PRIME_MODULUS, '0);
        send_req(7, 8, 9, 10);
        drain();

        run_phase(2, 97, 55);
        run_phase('1, BIG_PRIME, 55);
        run_phase($urandom, BIG_PRIME, 55);
        run_phase(5, 15, 50);
        run_phase(3, 0, 40);
        run_phase(1, '1, 55);
        run_phase($urandom_range(0, 6), 7, 50);
        run_phase(0, 23, 50);

        $display("%0d sums checked (%0d at infinity), %0d cycles", sum_cnt, inf_cnt, cycles);
        $display("covered doubling, inverse, equal-x and unreduced pairs; prime, composite, zero p");
        if (fail_cnt == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d failures, %0d sums never returned", fail_cnt, pending);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/ecpa_pkg.sv
hw/rtl/ecpa_dp.sv
hw/rtl/ecpa_ctrl.sv
hw/rtl/ec_point_add_mod_p_top.sv
sim/ecpa_tb_pkg.sv
sim/ecpa_checker.sv
sim/tb.sv
